// ===== rtl/nkc_pkg.sv =====
// Package for the next-k-combination generator: field widths, register
// indexes, operation codes and the effective configuration type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nkc_pkg;

  localparam int unsigned UNIV_W  = 11;  // universe_size register
  localparam int unsigned COUNT_W = 5;   // choose_count register
  localparam int unsigned POS_W   = 4;   // position field
  localparam int unsigned VAL_W   = 11;  // index value field
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_UNIVERSE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHOOSE   = CFG_IDX_W'(1);

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Effective universe size and choose count after clamping.
  typedef struct packed {
    logic [UNIV_W-1:0]  n;
    logic [COUNT_W-1:0] k;
  } eff_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/nkc_limits.sv =====
// Clamps the raw configuration registers into the effective universe size
// and choose count. Depends on nkc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nkc_limits #(
  parameter int unsigned MAX_CHOOSE   = 16,
  parameter int unsigned MAX_UNIVERSE = 1024
) (
  input  wire logic [nkc_pkg::UNIV_W-1:0]  univ_i,
  input  wire logic [nkc_pkg::COUNT_W-1:0] count_i,
  output nkc_pkg::eff_cfg_t                eff_o
);
  import nkc_pkg::*;

  logic [UNIV_W-1:0]  n;
  logic [COUNT_W-1:0] k;

  always_comb begin
    n = (univ_i == '0) ? UNIV_W'(1) : univ_i;
    if (32'(n) > MAX_UNIVERSE) begin
      n = UNIV_W'(MAX_UNIVERSE);
    end
    k = (count_i == '0) ? COUNT_W'(1) : count_i;
    if (32'(k) > MAX_CHOOSE) begin
      k = COUNT_W'(MAX_CHOOSE);
    end
    // never choose more than the universe holds
    if (UNIV_W'(k) > n) begin
      k = COUNT_W'(n);
    end
  end

  assign eff_o = '{n: n, k: k};

endmodule

`default_nettype wire

// ===== rtl/next_k_combination_generator.sv =====
// Top level of the next-k-combination generator: stream ports, configuration
// registers, combination memory and sequencer. Depends on nkc_pkg, nkc_limits.
`timescale 1ns / 1ps
`default_nettype none

// Holds a strictly increasing combination of k one-based indices taken from
// 1..n in a small synchronous memory (one write port and one registered read
// port). A load request writes one position and gives no result. An advance
// request reads the last position, adds one and walks left one memory read
// per cycle while a position exceeds its ceiling n+1-k+pos; it then writes
// the refilled positions one per cycle and finally reads and emits all k
// positions, one result per cycle while the output side is ready. An advance
// thus steps through the carry walk, the refill and the emission in turn.
// A carry past the first position clamps to the final combination. The
// emitted more flag drops to 0 once the final combination is reached.
// Configuration is sampled combinationally and must only change while
// idle. The memory has no reset: reading a never-loaded position returns
// garbage.
module next_k_combination_generator #(
  parameter int unsigned MAX_CHOOSE   = 16,
  parameter int unsigned MAX_UNIVERSE = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [nkc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [nkc_pkg::UNIV_W-1:0]      cfg_data_i,
  // request stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [3:0] load_position, [14:4] load_value
  input  wire logic        s_axis_tuser,   // [0] op
  // result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,   // [3:0] position, [14:4] index_value
  output      logic        m_axis_tlast,
  output      logic        m_axis_tuser    // [0] more
);
  import nkc_pkg::*;

  localparam int unsigned AW = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
  localparam int unsigned VW = VAL_W + 1;  // room for the carry compare

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CARRY = 4'b0010,
    S_FILL  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [UNIV_W-1:0]  univ_q;
  logic [COUNT_W-1:0] count_q;
  eff_cfg_t           eff;

  logic [COUNT_W-1:0] pos_cnt_q, pos_cnt_d;   // carry position, then refill position
  logic [COUNT_W-1:0] emit_q, emit_d;
  logic [VAL_W-1:0]   fill_v_q, fill_v_d;
  logic               more_q, more_d;
  logic               ovalid_q, ovalid_d;
  logic [POS_W-1:0]   opos_q;
  logic               olast_q;

  // combination memory
  logic [VAL_W-1:0] comb_mem [MAX_CHOOSE];
  logic [VAL_W-1:0] rd_q;
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [VAL_W-1:0] wr_data;

  logic               in_acc;
  logic [POS_W-1:0]   ld_pos;
  logic [VAL_W-1:0]   ld_val;
  logic [COUNT_W-1:0] k_last;
  logic [VW-1:0]      cur_v, ceil_v;
  logic               emit_issue;

  nkc_limits #(
    .MAX_CHOOSE   (MAX_CHOOSE),
    .MAX_UNIVERSE (MAX_UNIVERSE)
  ) u_limits (
    .univ_i  (univ_q),
    .count_i (count_q),
    .eff_o   (eff)
  );

  assign in_acc = s_axis_tvalid & s_axis_tready;
  assign ld_pos = s_axis_tdata[POS_W-1:0];
  assign ld_val = s_axis_tdata[POS_W+VAL_W-1:POS_W];
  assign k_last = eff.k - COUNT_W'(1);

  // incremented position against its ceiling n+1-k+pos
  assign cur_v  = {1'b0, rd_q} + VW'(1);
  assign ceil_v = VW'(eff.n) + VW'(1) - VW'(eff.k) + VW'(pos_cnt_q);

  // take the next result read when the output register frees up
  assign emit_issue = (state_q == S_EMIT) && (emit_q != eff.k) &&
                      (!ovalid_q || m_axis_tready);

  // accept only when no result is left waiting, as an advance reuses the read register
  assign s_axis_tready = (state_q == S_IDLE) && (!ovalid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    pos_cnt_d = pos_cnt_q;
    emit_d    = emit_q;
    fill_v_d  = fill_v_q;
    more_d    = more_q;
    rd_en     = 1'b0;
    rd_addr   = AW'(emit_q);
    wr_en     = 1'b0;
    wr_addr   = AW'(pos_cnt_q);
    wr_data   = fill_v_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == OP_ADVANCE) begin
            // fetch the last position and start the carry walk
            rd_en     = 1'b1;
            rd_addr   = AW'(k_last);
            pos_cnt_d = k_last;
            state_d   = S_CARRY;
          end else if (32'(ld_pos) < MAX_CHOOSE) begin
            wr_en   = 1'b1;
            wr_addr = AW'(ld_pos);
            wr_data = ld_val;
          end
        end
      end

      S_CARRY: begin
        if (cur_v > ceil_v) begin
          if (pos_cnt_q == '0) begin
            // carried past the first position: clamp to the final combination
            more_d    = 1'b0;
            pos_cnt_d = '0;
            fill_v_d  = VAL_W'(VW'(eff.n) + VW'(1) - VW'(eff.k));
            state_d   = S_FILL;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = AW'(pos_cnt_q - COUNT_W'(1));
            pos_cnt_d = pos_cnt_q - COUNT_W'(1);
          end
        end else begin
          wr_en   = 1'b1;
          wr_data = cur_v[VAL_W-1:0];
          more_d  = !((pos_cnt_q == '0) && (cur_v == ceil_v));
          if (pos_cnt_q == k_last) begin
            emit_d  = '0;
            state_d = S_EMIT;
          end else begin
            pos_cnt_d = pos_cnt_q + COUNT_W'(1);
            fill_v_d  = cur_v[VAL_W-1:0] + VAL_W'(1);
            state_d   = S_FILL;
          end
        end
      end

      S_FILL: begin
        // refill later positions consecutively
        wr_en     = 1'b1;
        pos_cnt_d = pos_cnt_q + COUNT_W'(1);
        fill_v_d  = fill_v_q + VAL_W'(1);
        if (pos_cnt_q == k_last) begin
          emit_d  = '0;
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (emit_issue) begin
          rd_en  = 1'b1;
          emit_d = emit_q + COUNT_W'(1);
          if (emit_q == k_last) begin
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (emit_issue) begin
      ovalid_d = 1'b1;
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      univ_q    <= UNIV_W'(16);
      count_q   <= COUNT_W'(4);
      pos_cnt_q <= '0;
      emit_q    <= '0;
      more_q    <= 1'b1;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_cnt_q <= pos_cnt_d;
      emit_q    <= emit_d;
      more_q    <= more_d;
      ovalid_q  <= ovalid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_UNIVERSE) begin
          univ_q <= cfg_data_i;
        end else if (cfg_idx_i == CFG_CHOOSE) begin
          count_q <= cfg_data_i[COUNT_W-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    fill_v_q <= fill_v_d;
    if (emit_issue) begin
      opos_q  <= POS_W'(emit_q);
      olast_q <= (emit_q == k_last);
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      comb_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= comb_mem[rd_addr];
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, rd_q, opos_q};
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = more_q;

endmodule

`default_nettype wire

// ===== rtl/nkc_checker.sv =====
// Port-level checker for the next-k-combination generator and its bind.
// Depends on next_k_combination_generator.
`timescale 1ns / 1ps
`default_nettype none

module nkc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser
);

  logic       out_acc;
  logic       mid_q;       // inside a combination
  logic [3:0] prev_pos_q;
  logic       prev_more_q;

  assign out_acc = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q       <= 1'b0;
      prev_pos_q  <= '0;
      prev_more_q <= 1'b0;
    end else if (out_acc) begin
      mid_q       <= !m_axis_tlast;
      prev_pos_q  <= m_axis_tdata[3:0];
      prev_more_q <= m_axis_tuser;
    end
  end

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a new request is never taken while a result waits unread
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("request accepted over a pending result");

  // each combination starts at position zero
  a_first_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !mid_q |-> m_axis_tdata[3:0] == 4'd0)
    else $error("combination does not start at position zero");

  // positions step by one and the more flag holds across a combination
  a_next_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && mid_q |-> m_axis_tdata[3:0] == prev_pos_q + 4'd1 &&
                         m_axis_tuser == prev_more_q)
    else $error("position sequence or more flag broken");

endmodule

bind next_k_combination_generator nkc_checker u_nkc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/nkc_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the next-k-combination generator: follows the register
// port and both streams, predicts each advance and compares every result.
// Depends on nkc_pkg.
module nkc_result_checker #(
  parameter int unsigned MAX_CHOOSE   = 16,
  parameter int unsigned MAX_UNIVERSE = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nkc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [nkc_pkg::UNIV_W-1:0]      cfg_data_i,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,   // [3:0] load_position, [14:4] load_value
  input  logic                            s_axis_tuser,   // [0] op
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [15:0]                     m_axis_tdata,   // [3:0] position, [14:4] index_value
  input  logic                            m_axis_tlast,
  input  logic                            m_axis_tuser,   // [0] more
  output int                              mismatch_count,
  output int                              pending_results,
  output int                              checked_results
);
  import nkc_pkg::*;

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] index_value;
    logic             last;
    logic             more;
  } combo_result_t;

  combo_result_t     expected_results[$];
  combo_result_t     seen;
  combo_result_t     want;
  logic [UNIV_W-1:0]  universe_size_q;
  logic [COUNT_W-1:0] choose_count_q;
  int                combination[MAX_CHOOSE];

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t ns nkc_result_checker: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Step the held combination to its successor and queue one result per position.
  task automatic advance_combination();
    int n;
    int k;
    int pos;
    int j;
    logic more;
    combo_result_t r;
    n = universe_size_q;
    if (n < 1) n = 1;
    if (n > int'(MAX_UNIVERSE)) n = MAX_UNIVERSE;
    k = choose_count_q;
    if (k < 1) k = 1;
    if (k > int'(MAX_CHOOSE)) k = MAX_CHOOSE;
    if (k > n) k = n;
    pos = k - 1;
    combination[pos]++;
    more = 1'b1;
    while (combination[pos] > n + 1 - k + pos) begin
      pos--;
      if (pos < 0) break;
      combination[pos]++;
    end
    if (pos < 0) begin
      // carried off the front: park on the final combination
      for (j = 0; j < k; j++) combination[j] = n + 1 - k + j;
      more = 1'b0;
    end else begin
      for (j = pos + 1; j < k; j++) combination[j] = combination[j-1] + 1;
      if (pos == 0 && combination[0] == n + 1 - k) more = 1'b0;
    end
    for (j = 0; j < k; j++) begin
      r.position    = POS_W'(j);
      r.index_value = VAL_W'(combination[j]);
      r.last        = (j == k - 1);
      r.more        = more;
      expected_results.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      universe_size_q = UNIV_W'(16);
      choose_count_q  = COUNT_W'(4);
      expected_results.delete();
      foreach (combination[j]) combination[j] = 0;
      mismatch_count  = 0;
      checked_results = 0;
      pending_results = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.position    = m_axis_tdata[3:0];
        seen.index_value = m_axis_tdata[14:4];
        seen.last        = m_axis_tlast;
        seen.more        = m_axis_tuser;
        checked_results++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result, position %0d index %0d",
                                    seen.position, seen.index_value));
        end else begin
          want = expected_results.pop_front();
          if (seen.position !== want.position)
            report_mismatch($sformatf("position got %0d expected %0d",
                                      seen.position, want.position));
          if (seen.index_value !== want.index_value)
            report_mismatch($sformatf("position %0d index_value got %0d expected %0d",
                                      want.position, seen.index_value, want.index_value));
          if (seen.last !== want.last)
            report_mismatch($sformatf("position %0d last got %0b expected %0b",
                                      want.position, seen.last, want.last));
          if (seen.more !== want.more)
            report_mismatch($sformatf("position %0d more got %0b expected %0b",
                                      want.position, seen.more, want.more));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_LOAD) begin
          if (int'(s_axis_tdata[3:0]) < int'(MAX_CHOOSE))
            combination[s_axis_tdata[3:0]] = s_axis_tdata[14:4];
        end else begin
          advance_combination();
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_UNIVERSE: begin
            universe_size_q = cfg_data_i;
          end
          CFG_CHOOSE: begin
            choose_count_q = cfg_data_i[COUNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      pending_results = expected_results.size();
    end
  end

endmodule

// ===== tb/next_k_combination_generator_test.sv =====
`timescale 1ns / 1ps
// Top of the next-k-combination generator testbench: clock, reset, request
// and result stimulus, register writes and the verdict. Depends on nkc_pkg,
// nkc_result_checker and the generator RTL.
module next_k_combination_generator_test;
  import nkc_pkg::*;

  localparam int unsigned MAX_CHOOSE   = 16;
  localparam int unsigned MAX_UNIVERSE = 1024;

  localparam int REQUEST_TARGET = 320;
  localparam int GAP_MAX        = 19;
  // Idle time added once the last result is out, covering any work left
  // in flight.
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_CYCLES    = 400;
  localparam longint TIMEOUT_NS = 40_000_000;

  // Register indexes outside the map: writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = CFG_IDX_W'(3);

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [UNIV_W-1:0]    cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata;   // [3:0] load_position, [14:4] load_value
  logic                 s_axis_tuser;   // [0] op
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [15:0]          m_axis_tdata;   // [3:0] position, [14:4] index_value
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;   // [0] more

  int mismatch_count;
  int pending_results;
  int checked_results;

  // Idle shaping: upper bound of the per-item wait on each side, and a
  // one-off long hold-off handed to the result side.
  int tx_gap_max;
  int rx_gap_max;
  int rx_hold_cycles;

  int request_count;
  int advance_count;
  int write_count;
  int setting_count;

  // Register values as last written, and which positions hold a loaded
  // index: an advance is only issued once every live position has one.
  logic [UNIV_W-1:0]     universe_set;
  logic [COUNT_W-1:0]    choose_set;
  logic [MAX_CHOOSE-1:0] loaded_mask;

  int fixed_universe[10] = '{1024, 1, 0, 2047, 16, 5, 3, 1025, 2, 64};
  int fixed_choose[10]   = '{16, 1, 0, 31, 4, 20, 2, 17, 2, 7};

  next_k_combination_generator #(
    .MAX_CHOOSE  (MAX_CHOOSE),
    .MAX_UNIVERSE(MAX_UNIVERSE)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  nkc_result_checker #(
    .MAX_CHOOSE  (MAX_CHOOSE),
    .MAX_UNIVERSE(MAX_UNIVERSE)
  ) result_watch (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .m_axis_tuser   (m_axis_tuser),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results),
    .checked_results(checked_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Effective universe and count as the block clamps them.
  function automatic int live_universe();
    int n;
    n = universe_set;
    if (n < 1) n = 1;
    if (n > int'(MAX_UNIVERSE)) n = MAX_UNIVERSE;
    return n;
  endfunction

  function automatic int live_choose();
    int k;
    k = choose_set;
    if (k < 1) k = 1;
    if (k > int'(MAX_CHOOSE)) k = MAX_CHOOSE;
    if (k > live_universe()) k = live_universe();
    return k;
  endfunction

  // Offer one request after a random gap and hold it until it is taken.
  // Called and returning at a falling edge; valid is assigned once per step.
  task automatic send_request(input logic op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] value);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {1'b0, value, pos};
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    request_count++;
    if (op == OP_LOAD) begin
      loaded_mask[pos] = 1'b1;
    end else begin
      advance_count++;
    end
  endtask

  task automatic send_load(input int pos, input int value);
    send_request(OP_LOAD, POS_W'(pos), VAL_W'(value));
  endtask

  // Skip the advance while a live position was never loaded; the unused
  // fields carry noise.
  task automatic send_advance();
    int unsigned need;
    need = (32'd1 << live_choose()) - 1;
    if ((32'(loaded_mask) & need) == need)
      send_request(OP_ADVANCE, POS_W'($urandom()), VAL_W'($urandom()));
  endtask

  // Drop valid, wait for every expected result, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_idx_i  <= idx;
    cfg_data_i <= UNIV_W'(data);
    cfg_we_i   <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    write_count++;
    if (idx == CFG_UNIVERSE) universe_set = UNIV_W'(data);
    else if (idx == CFG_CHOOSE) choose_set = COUNT_W'(data);
  endtask

  // Reconfigure only once the block is idle; now and then slip in a write
  // to an unmapped index first.
  task automatic apply_setting(input int universe_value, input int choose_value);
    drain();
    if ($urandom_range(0, 2) == 0)
      write_register($urandom_range(0, 1) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI,
                     $urandom_range(0, 2047));
    write_register(CFG_UNIVERSE, universe_value);
    write_register(CFG_CHOOSE, choose_value);
    setting_count++;
  endtask

  // Load a valid increasing combination. A random tail sits at its ceilings
  // so that advances carry, reach the final combination and run off the front.
  task automatic load_random_combination();
    int vals[MAX_CHOOSE];
    int n;
    int k;
    int tail;
    int lo;
    int hi;
    int j;
    n = live_universe();
    k = live_choose();
    tail = $urandom_range(0, k);
    for (j = 0; j < k; j++) begin
      lo = (j == 0) ? 1 : vals[j-1] + 1;
      hi = n + 1 - k + j;
      if (j >= k - tail) vals[j] = hi;
      else if ($urandom_range(0, 1)) vals[j] = $urandom_range(lo, hi);
      else vals[j] = $urandom_range(lo, (hi < lo + 3) ? hi : lo + 3);
    end
    for (j = 0; j < k; j++) send_load(j, vals[j]);
  endtask

  // Mostly well-formed runs: load then step. The rest is stray loads anywhere
  // and partial reloads that break the ordering before an advance.
  task automatic run_sequences(input int budget);
    int start_count;
    int kind;
    start_count = request_count;
    while (request_count - start_count < budget) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        load_random_combination();
        repeat ($urandom_range(1, 6)) send_advance();
      end else if (kind <= 8) begin
        repeat ($urandom_range(1, 4)) send_load($urandom_range(0, 15), $urandom_range(0, 1025));
        send_advance();
      end else begin
        repeat ($urandom_range(1, 3))
          send_load($urandom_range(0, live_choose() - 1), $urandom_range(0, 1025));
        send_advance();
      end
      if ($urandom_range(0, 7) == 0) drain();
    end
  endtask

  // Result side: wait a random number of cycles before each result and honour
  // a long hold-off when one is asked for.
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles) @(negedge clk_i);
        rx_hold_cycles = 0;
      end
      gap = $urandom_range(0, rx_gap_max);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid && rx_hold_cycles == 0) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout: results still outstanding or requests not taken");
    $display("next_k_combination_generator_test: done, errors");
    $finish;
  end

  initial begin
    int i;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_UNIVERSE;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_LOAD;
    m_axis_tready  = 1'b0;
    tx_gap_max     = GAP_MAX;
    rx_gap_max     = GAP_MAX;
    rx_hold_cycles = 0;
    request_count  = 0;
    advance_count  = 0;
    write_count    = 0;
    setting_count  = 0;
    universe_set   = UNIV_W'(16);
    choose_set     = COUNT_W'(4);
    loaded_mask    = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part on the reset setting: 16 points, 4 chosen.
    // Plain step of the last position.
    send_load(0, 1);
    send_load(1, 2);
    send_load(2, 3);
    send_load(3, 4);
    send_advance();
    // Final combination: the carry runs off the front, clamp and drop more,
    // then stay parked on a second advance.
    for (i = 0; i < 4; i++) send_load(i, 13 + i);
    send_advance();
    send_advance();
    // Carry that stops on the first position at its ceiling: more drops.
    send_load(0, 12);
    send_advance();
    // Carry across two positions and refill.
    send_load(0, 1);
    send_load(1, 2);
    send_load(2, 15);
    send_load(3, 16);
    send_advance();
    // Loads beyond the count are stored but never emitted.
    send_load(15, 1025);
    send_load(4, 0);
    // Out-of-range last index forces a carry; a zero index at the front.
    send_load(3, 1025);
    send_advance();
    send_load(0, 0);
    send_advance();

    // Back-pressure: park the result side while advances keep coming so the
    // block fills and stalls its request side, then pause until all is back.
    apply_setting(1024, 16);
    load_random_combination();
    drain();
    tx_gap_max     = 0;
    rx_hold_cycles = HOLD_CYCLES;
    repeat (6) send_advance();
    drain();

    // Fixed settings, the extremes and out-of-range values among them; vary
    // the idling so gaps land on every phase, with some runs gap-free.
    for (i = 0; i < 10; i++) begin
      tx_gap_max = (i % 3 == 1) ? 0 : GAP_MAX;
      rx_gap_max = (i % 4 == 2) ? 0 : GAP_MAX;
      apply_setting(fixed_universe[i], fixed_choose[i]);
      run_sequences(18);
    end

    // Random settings, mostly small, until the request budget is spent.
    while (request_count < REQUEST_TARGET) begin
      tx_gap_max = $urandom_range(0, 2) ? GAP_MAX : 0;
      rx_gap_max = $urandom_range(0, 2) ? GAP_MAX : 0;
      if ($urandom_range(0, 4) == 0) apply_setting($urandom_range(0, 2047), $urandom_range(0, 31));
      else apply_setting($urandom_range(1, 64), $urandom_range(1, 8));
      run_sequences(20);
    end

    drain();
    $display("Covered %0d requests (%0d advances) over %0d settings and %0d register writes",
             request_count, advance_count, setting_count, write_count);
    $display("Compared %0d results, %0d mismatches", checked_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("next_k_combination_generator_test: done, clean");
    end else begin
      $display("next_k_combination_generator_test: done, errors");
    end
    $finish;
  end

endmodule
